/* hdl/memory_bandwidth_regulator_macros.svh */
// Assertion macros used by the regulator step module.
`ifndef MEMORY_BANDWIDTH_REGULATOR_MACROS_SVH
`define MEMORY_BANDWIDTH_REGULATOR_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("regulator check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("regulator check failed");

`endif

/* hdl/mbr_pkg.sv */
`default_nettype none

package mbr_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_PERIOD_TICKS    = 2'd0;
    localparam logic [1:0] REG_EVENT_BUDGET    = 2'd1;
    localparam logic [1:0] REG_REGULATE_ENABLE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] PERIOD_TICKS_RST = 32'd1000;
    localparam logic [31:0] EVENT_BUDGET_RST = 32'd0;

    // Padded widths of the stream words.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [31:0] period_ticks;
        logic [31:0] event_budget;
        logic        regulate_enable;
    } mbr_cfg_t;

    typedef struct packed {
        logic       tick;
        logic [3:0] event_count;
        logic       core_reset;
    } mbr_item_t;

    typedef struct packed {
        logic        stall_res;
        logic        period_end;
        logic        overflow;
        logic [31:0] events_left;
    } mbr_result_t;

endpackage

`default_nettype wire

/* hdl/mbr_cfg_regs.sv */
`default_nettype none

module mbr_cfg_regs
    import mbr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output mbr_cfg_t         cfg,
    output logic             cfg_clear
);

    mbr_cfg_t cfg_reg;
    mbr_cfg_t cfg_next;

    // Decode the write; an index beyond the register list changes nothing.
    always_comb
    begin
        cfg_next  = cfg_reg;
        cfg_clear = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PERIOD_TICKS:
                begin
                    cfg_next.period_ticks = cfg_data;
                    cfg_clear = 1'b1;
                end
                REG_EVENT_BUDGET:
                begin
                    cfg_next.event_budget = cfg_data;
                    cfg_clear = 1'b1;
                end
                REG_REGULATE_ENABLE:
                begin
                    cfg_next.regulate_enable = cfg_data[0];
                    cfg_clear = 1'b1;
                end
                default:
                begin
                    cfg_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ticks    <= PERIOD_TICKS_RST;
            cfg_reg.event_budget    <= EVENT_BUDGET_RST;
            cfg_reg.regulate_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/mbr_in_reg.sv */
`default_nettype none

module mbr_in_reg
    import mbr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire mbr_item_t in_item,
    output logic           item_valid,
    input  wire logic      item_take,
    output mbr_item_t      item
);

    logic      valid_reg;
    mbr_item_t item_reg;

    // The register frees up in the same cycle that the step consumes it.
    assign in_ready = !valid_reg || item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload register, loaded with each accepted word.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* hdl/mbr_step.sv */
`default_nettype none
`include "memory_bandwidth_regulator_macros.svh"

module mbr_step
    import mbr_pkg::*;
#(
    parameter int COUNTER_BITS         = 32,
    parameter int EVENTS_PER_CYCLE_MAX = 15
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mbr_cfg_t  cfg,
    input  wire logic      cfg_clear,
    input  wire logic      fire,
    input  wire mbr_item_t item,
    output mbr_result_t    result
);

    localparam int EW     = COUNTER_BITS + 1;
    localparam int CMP_TW = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;
    localparam int CMP_EW = (EW > 32) ? EW : 32;
    localparam logic [7:0] EV_MAX = 8'(EVENTS_PER_CYCLE_MAX);

    logic [COUNTER_BITS-1:0] ticks_reg, ticks_next;
    logic [EW-1:0]           events_reg, events_next;
    logic                    block_reg, block_next;
    logic                    sticky_reg, sticky_next;

    logic [3:0]              ev_clamped;
    logic [COUNTER_BITS-1:0] ticks_inc;
    logic [31:0]             plen;
    logic                    pend;
    logic [EW-1:0]           events_base;
    logic [EW:0]             events_sum;
    logic [EW-1:0]           events_sat;
    logic [CMP_EW-1:0]       budget_ext;
    logic [CMP_EW-1:0]       base_ext;
    logic [CMP_EW-1:0]       sat_ext;
    logic [CMP_EW-1:0]       left_diff;
    logic                    ovf;
    logic                    sticky_new;
    logic                    block_new;

    // Per-cycle event clamp.
    assign ev_clamped = ({4'd0, item.event_count} > EV_MAX) ? EV_MAX[3:0] : item.event_count;

    // Tick counter advance and period end; a zero period acts as one tick.
    assign ticks_inc = (item.tick && (ticks_reg != '1)) ? ticks_reg + COUNTER_BITS'(1)
                                                        : ticks_reg;
    assign plen = (cfg.period_ticks == 32'd0) ? 32'd1 : cfg.period_ticks;
    assign pend = item.tick && (CMP_TW'(ticks_inc) >= CMP_TW'(plen));

    // Events count into the new period when this word closed the old one.
    assign events_base = pend ? '0 : events_reg;
    assign events_sum  = {1'b0, events_base} + (EW + 1)'(ev_clamped);
    assign events_sat  = events_sum[EW] ? '1 : events_sum[EW-1:0];

    // First crossing of the budget raises the block.
    assign budget_ext = CMP_EW'(cfg.event_budget);
    assign base_ext   = CMP_EW'(events_base);
    assign sat_ext    = CMP_EW'(events_sat);
    assign ovf        = (base_ext <= budget_ext) && (sat_ext > budget_ext);
    assign left_diff  = budget_ext - sat_ext;

    assign sticky_new = (sticky_reg && !pend) || item.core_reset;
    assign block_new  = ((block_reg && !pend) || ovf) && !sticky_new;

    // Next state and result of one word.
    always_comb
    begin
        ticks_next  = ticks_reg;
        events_next = events_reg;
        block_next  = block_reg;
        sticky_next = sticky_reg;
        result.stall_res   = 1'b0;
        result.period_end  = 1'b0;
        result.overflow    = 1'b0;
        result.events_left = cfg.event_budget;
        if (!cfg.regulate_enable)
        begin
            ticks_next  = '0;
            events_next = '0;
            block_next  = 1'b0;
            sticky_next = 1'b0;
        end
        else
        begin
            ticks_next  = pend ? '0 : ticks_inc;
            events_next = events_sat;
            block_next  = block_new;
            sticky_next = sticky_new;
            result.stall_res   = block_new;
            result.period_end  = pend;
            result.overflow    = ovf;
            result.events_left = (budget_ext > sat_ext) ? left_diff[31:0] : 32'd0;
        end
    end

    // Regulation state; a configuration write starts a fresh period.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg  <= '0;
            events_reg <= '0;
            block_reg  <= 1'b0;
            sticky_reg <= 1'b0;
        end
        else if (cfg_clear)
        begin
            ticks_reg  <= '0;
            events_reg <= '0;
            block_reg  <= 1'b0;
            sticky_reg <= 1'b0;
        end
        else if (fire)
        begin
            ticks_reg  <= ticks_next;
            events_reg <= events_next;
            block_reg  <= block_next;
            sticky_reg <= sticky_next;
        end
    end

    // A held block and a set reset flag never coexist.
    `MBR_ASSERT_NOW(a_block_sticky_excl, clk, rst_n, block_reg, !sticky_reg)
    // A held block means the period's events are above the budget.
    `MBR_ASSERT_NOW(a_block_over_budget, clk, rst_n, block_reg,
        CMP_EW'(events_reg) > CMP_EW'(cfg.event_budget))
    // A closed period restarts the tick count.
    `MBR_ASSERT_NEXT(a_period_restart, clk, rst_n, fire && !cfg_clear && result.period_end,
        ticks_reg == '0)
    // With regulation off the state stays cleared.
    `MBR_ASSERT_NEXT(a_disabled_clear, clk, rst_n, fire && !cfg.regulate_enable,
        (events_reg == '0) && !block_reg)

endmodule

`default_nettype wire

/* hdl/mbr_out_reg.sv */
`default_nettype none

module mbr_out_reg
    import mbr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    output logic             can_load,
    input  wire mbr_result_t result_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output mbr_result_t      result_out
);

    logic        valid_reg;
    mbr_result_t result_reg;

    // Loads when empty or when the held word leaves in this cycle.
    assign can_load = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

`default_nettype wire

/* hdl/memory_bandwidth_regulator.sv */
// A word accepted into the input register passes through the regulation step into the output register.
// Throughput: one word per cycle while the output is not held by backpressure; the regulation state updates per word.
// The input register and the output register each hold one word under backpressure.
// Reset (rst_n low, asynchronous) empties both registers, clears the regulation state,
// and loads period 1000 ticks, budget 0 and regulation disabled.
`default_nettype none

module memory_bandwidth_regulator
    import mbr_pkg::*;
#(
    parameter int COUNTER_BITS         = 32,
    parameter int EVENTS_PER_CYCLE_MAX = 15
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [0] tick, [4:1] event_count, [5] core_reset, [7:6] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] stall_res, [1] period_end, [2] overflow, [34:3] events_left, [39:35] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [31:0]           cfg_data
);

    mbr_cfg_t    cfg;
    logic        cfg_clear;
    mbr_item_t   in_item;
    mbr_item_t   item;
    logic        item_valid;
    logic        can_load;
    logic        fire;
    mbr_result_t result;
    mbr_result_t result_out;

    // Unpack the input word.
    assign in_item.tick        = s_axis_tdata[0];
    assign in_item.event_count = s_axis_tdata[4:1];
    assign in_item.core_reset  = s_axis_tdata[5];

    assign fire = item_valid && can_load;

    mbr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_clear (cfg_clear)
    );

    mbr_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (fire),
        .item       (item)
    );

    mbr_step #(
        .COUNTER_BITS         (COUNTER_BITS),
        .EVENTS_PER_CYCLE_MAX (EVENTS_PER_CYCLE_MAX)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_clear (cfg_clear),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    mbr_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .can_load   (can_load),
        .result_in  (result),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .result_out (result_out)
    );

    // Pack the result word.
    assign m_axis_tdata = {5'd0, result_out.events_left, result_out.overflow,
                           result_out.period_end, result_out.stall_res};

endmodule

`default_nettype wire
